// File: sv/atd_pkg.sv
// Shared types, constants and microcode for the accelerometer tilt smoother.
// Holds the control-word layout, op and jump codes, the atan table and the clamp.
// No dependencies; used by atd_seq, atd_lane and the top level.
package atd_pkg;

	// Angle limit, +-90 degrees at 1/256 degree per LSB
	localparam logic signed [17:0] ATD_ANG_LIM  = 18'sd23040;
	localparam logic signed [15:0] ATD_ANG_MAX  = 16'sd23040;
	localparam logic signed [15:0] ATD_ANG_MIN  = -16'sd23040;

	// Register reset values and indexes
	localparam logic [15:0] ATD_WEIGHT_RST = 16'd13107;
	localparam int          ATD_CFG_IDX_W  = 1;
	localparam int          ATD_CFG_DATA_W = 16;
	localparam logic [ATD_CFG_IDX_W-1:0] CFG_SENSOR = 1'b0;
	localparam logic [ATD_CFG_IDX_W-1:0] CFG_WEIGHT = 1'b1;

	// Iteration counts
	localparam int ATD_ROOT_W     = 24;  // result bits of the square root
	localparam int ATD_CORD_STEPS = 20;  // CORDIC micro-rotations
	localparam int ATD_CNT_W      = 5;
	localparam int ATD_PC_W       = 4;

	// Datapath ops
	localparam logic [3:0] OP_NOP   = 4'd0;
	localparam logic [3:0] OP_SQA   = 4'd1;
	localparam logic [3:0] OP_SQB   = 4'd2;
	localparam logic [3:0] OP_RINIT = 4'd3;
	localparam logic [3:0] OP_RSTEP = 4'd4;
	localparam logic [3:0] OP_CINIT = 4'd5;
	localparam logic [3:0] OP_CSTEP = 4'd6;
	localparam logic [3:0] OP_ROUND = 4'd7;
	localparam logic [3:0] OP_SMUL  = 4'd8;
	localparam logic [3:0] OP_SADD  = 4'd9;

	// Jump conditions: taken -> target, else fall through to pc+1
	localparam logic [2:0] J_NONE    = 3'd0;
	localparam logic [2:0] J_ALWAYS  = 3'd1;
	localparam logic [2:0] J_NOVALID = 3'd2;
	localparam logic [2:0] J_SKIP    = 3'd3;
	localparam logic [2:0] J_LOOP    = 3'd4;
	localparam logic [2:0] J_OBUSY   = 3'd5;

	// Program addresses
	localparam logic [ATD_PC_W-1:0] P_OUT   = 4'd0;
	localparam logic [ATD_PC_W-1:0] P_WAIT  = 4'd1;
	localparam logic [ATD_PC_W-1:0] P_SQA   = 4'd2;
	localparam logic [ATD_PC_W-1:0] P_SQB   = 4'd3;
	localparam logic [ATD_PC_W-1:0] P_RINIT = 4'd4;
	localparam logic [ATD_PC_W-1:0] P_RSTEP = 4'd5;
	localparam logic [ATD_PC_W-1:0] P_CINIT = 4'd6;
	localparam logic [ATD_PC_W-1:0] P_CSTEP = 4'd7;
	localparam logic [ATD_PC_W-1:0] P_ROUND = 4'd8;
	localparam logic [ATD_PC_W-1:0] P_SMUL  = 4'd9;
	localparam logic [ATD_PC_W-1:0] P_SADD  = 4'd10;

	// Control handed from the sequencer to both lanes
	typedef struct packed {
		logic [3:0]           op;
		logic [ATD_CNT_W-1:0] iter;
	} atd_ctl_t;

	// One microcode word
	typedef struct packed {
		logic [3:0]           op;
		logic [2:0]           jc;
		logic [ATD_PC_W-1:0]  target;
		logic [ATD_CNT_W-1:0] lim;
		logic                 accept;
		logic                 out_ld;
	} atd_cw_t;

	// Microcode ROM
	function automatic atd_cw_t atd_ucode(input logic [ATD_PC_W-1:0] pc);
		atd_cw_t cw;
		cw.op     = OP_NOP;
		cw.jc     = J_NONE;
		cw.target = P_WAIT;
		cw.lim    = '0;
		cw.accept = 1'b0;
		cw.out_ld = 1'b0;
		case (pc)
			P_OUT: begin
				cw.out_ld = 1'b1;
				cw.jc     = J_OBUSY;
				cw.target = P_OUT;
			end
			P_WAIT: begin
				cw.accept = 1'b1;
				cw.jc     = J_NOVALID;
				cw.target = P_WAIT;
			end
			P_SQA: begin
				cw.op     = OP_SQA;
				cw.jc     = J_SKIP;
				cw.target = P_OUT;
			end
			P_SQB:   cw.op = OP_SQB;
			P_RINIT: cw.op = OP_RINIT;
			P_RSTEP: begin
				cw.op     = OP_RSTEP;
				cw.jc     = J_LOOP;
				cw.target = P_RSTEP;
				cw.lim    = ATD_CNT_W'(ATD_ROOT_W - 1);
			end
			P_CINIT: cw.op = OP_CINIT;
			P_CSTEP: begin
				cw.op     = OP_CSTEP;
				cw.jc     = J_LOOP;
				cw.target = P_CSTEP;
				cw.lim    = ATD_CNT_W'(ATD_CORD_STEPS - 1);
			end
			P_ROUND: cw.op = OP_ROUND;
			P_SMUL:  cw.op = OP_SMUL;
			P_SADD: begin
				cw.op     = OP_SADD;
				cw.jc     = J_ALWAYS;
				cw.target = P_OUT;
			end
			default: begin
				cw.jc     = J_ALWAYS;
				cw.target = P_WAIT;
			end
		endcase
		return cw;
	endfunction

	// round(atan(2^-i) * 65536), degrees
	function automatic logic [21:0] atd_atan(input logic [ATD_CNT_W-1:0] i);
		logic [21:0] v;
		case (i)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

	// Clamp to +-90 degrees
	function automatic logic signed [15:0] atd_clamp(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > ATD_ANG_LIM)
			r = ATD_ANG_MAX;
		else if (v < -ATD_ANG_LIM)
			r = ATD_ANG_MIN;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

// File: sv/atd_seq.sv
// Microcode sequencer: program counter, loop counter and jump logic.
// Reads control words from atd_pkg::atd_ucode and drives both angle lanes.
// Depends on atd_pkg.
module atd_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              upd,
	input  logic              out_busy,
	output atd_pkg::atd_ctl_t ctl,
	output logic              rdy,
	output logic              out_ld
);

	logic [atd_pkg::ATD_PC_W-1:0]  pc_q;
	logic [atd_pkg::ATD_CNT_W-1:0] cnt_q;
	atd_pkg::atd_cw_t              cw;
	logic                          taken;

	assign cw = atd_pkg::atd_ucode(pc_q);

	// Jump condition select
	always_comb begin
		case (cw.jc)
			atd_pkg::J_NONE:    taken = 1'b0;
			atd_pkg::J_ALWAYS:  taken = 1'b1;
			atd_pkg::J_NOVALID: taken = !in_valid;
			atd_pkg::J_SKIP:    taken = !upd;
			atd_pkg::J_LOOP:    taken = (cnt_q != cw.lim);
			atd_pkg::J_OBUSY:   taken = out_busy;
			default:            taken = 1'b0;
		endcase
	end

	// Step and loop counters; the loop counter restarts at zero on loop exit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= atd_pkg::P_WAIT;
			cnt_q <= '0;
		end else begin
			pc_q <= taken ? cw.target : pc_q + 1'b1;
			if (cw.jc == atd_pkg::J_LOOP)
				cnt_q <= taken ? cnt_q + 1'b1 : '0;
		end
	end

	assign ctl.op   = cw.op;
	assign ctl.iter = cnt_q;
	assign rdy      = cw.accept;
	assign out_ld   = cw.out_ld & !out_busy;

endmodule

// File: sv/atd_lane.sv
// One angle lane: squares, bit-serial square root, CORDIC vectoring,
// rounding and exponential smoothing, with the smoothed angle as state.
// Depends on atd_pkg; stepped by atd_seq.
module atd_lane (
	input  logic                     clk,
	input  logic                     arst_n,
	input  atd_pkg::atd_ctl_t        ctl,
	input  logic signed [15:0]       num,
	input  logic signed [15:0]       leg_a,
	input  logic signed [15:0]       leg_b,
	input  logic [15:0]              weight,
	output logic signed [15:0]       angle
);

	logic [31:0]        sq_q;
	logic [47:0]        rad_q;
	logic [25:0]        rem_q;
	logic [23:0]        root_q;
	logic signed [27:0] vx_q, vy_q;
	logic signed [24:0] z_q;
	logic               nz_q;
	logic signed [15:0] ang_q;
	logic signed [33:0] prod_q;
	logic signed [15:0] sm_q;

	logic signed [16:0] ma, mb, diff;
	logic signed [33:0] mp;
	logic [27:0]        cur;
	logic [28:0]        trial;
	logic signed [27:0] dx, dy;
	logic signed [24:0] at, zr, zs;
	logic signed [34:0] ps, pt;
	logic signed [17:0] sum;

	// Shared multiplier: squares of the legs, then weight times difference
	assign diff = {ang_q[15], ang_q} - {sm_q[15], sm_q};
	always_comb begin
		case (ctl.op)
			atd_pkg::OP_SQA: begin
				ma = {leg_a[15], leg_a};
				mb = {leg_a[15], leg_a};
			end
			atd_pkg::OP_SQB: begin
				ma = {leg_b[15], leg_b};
				mb = {leg_b[15], leg_b};
			end
			default: begin
				ma = {1'b0, weight};
				mb = diff;
			end
		endcase
	end
	assign mp = ma * mb;

	// Restoring square root, one result bit per step
	assign cur   = {rem_q, rad_q[47:46]};
	assign trial = {1'b0, cur} - {3'b000, root_q, 2'b01};

	// CORDIC micro-rotation terms
	assign dx = vy_q >>> ctl.iter;
	assign dy = vx_q >>> ctl.iter;
	assign at = $signed({3'b000, atd_pkg::atd_atan(ctl.iter)});

	// Round accumulator to 1/256 degree
	assign zr = z_q + 25'sd128;
	assign zs = zr >>> 8;

	// Smoothing update, round half up
	assign ps  = {prod_q[33], prod_q} + 35'sd32768;
	assign pt  = ps >>> 16;
	assign sum = {{2{sm_q[15]}}, sm_q} + pt[17:0];

	// Working registers
	always_ff @(posedge clk) begin
		case (ctl.op)
			atd_pkg::OP_SQA: sq_q <= mp[31:0];
			atd_pkg::OP_SQB: sq_q <= sq_q + mp[31:0];
			atd_pkg::OP_RINIT: begin
				rad_q  <= {sq_q, 16'h0000};
				rem_q  <= '0;
				root_q <= '0;
			end
			atd_pkg::OP_RSTEP: begin
				rad_q <= {rad_q[45:0], 2'b00};
				if (!trial[28]) begin
					rem_q  <= trial[25:0];
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q  <= cur[25:0];
					root_q <= {root_q[22:0], 1'b0};
				end
			end
			atd_pkg::OP_CINIT: begin
				vx_q <= {4'b0000, root_q};
				vy_q <= {{4{num[15]}}, num, 8'h00};
				z_q  <= '0;
				nz_q <= (num == 16'sd0);
			end
			atd_pkg::OP_CSTEP: begin
				if (!vy_q[27]) begin
					vx_q <= vx_q + dx;
					vy_q <= vy_q - dy;
					z_q  <= z_q + at;
				end else begin
					vx_q <= vx_q - dx;
					vy_q <= vy_q + dy;
					z_q  <= z_q - at;
				end
			end
			atd_pkg::OP_ROUND: ang_q <= nz_q ? 16'sd0 : atd_pkg::atd_clamp(zs[17:0]);
			atd_pkg::OP_SMUL:  prod_q <= mp;
			default: ;
		endcase
	end

	// Smoothed angle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sm_q <= '0;
		else if (ctl.op == atd_pkg::OP_SADD)
			sm_q <= atd_pkg::atd_clamp(sum);
	end

	assign angle = sm_q;

endmodule

// File: sv/accel_tilt_angle_smoother_unit.sv
// Top level of the accelerometer tilt smoother: config registers, input capture,
// output register, the microcode sequencer and the pitch and roll lanes.
// Depends on atd_pkg, atd_seq and atd_lane.
//
// Takes one accelerometer sample per transfer and returns one result per sample:
// smoothed pitch and roll in 1/256 degree, clamped to +-90 degrees. When
// sensor_present is set and read_ok is high, both angles are recomputed and
// smoothed and sample_valid is 1; otherwise the stored angles come back with
// sample_valid low. Pitch and roll run side by side in two lanes under one
// microcode sequencer, and an updating sample runs through the squares, 24
// square-root steps, 20 CORDIC steps, rounding, smoothing and the output load
// before the next input transfer; a held sample goes from the squares straight
// to the output load. The next input is taken while a result waits in the
// output register; the sequencer stops only at the output load if that
// register is still full.
module accel_tilt_angle_smoother_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [atd_pkg::ATD_CFG_IDX_W-1:0]   cfg_index,
	input  logic [atd_pkg::ATD_CFG_DATA_W-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [15:0]                  accel_x,
	input  logic signed [15:0]                  accel_y,
	input  logic signed [15:0]                  accel_z,
	input  logic                                read_ok,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [15:0]                  pitch_angle,
	output logic signed [15:0]                  roll_angle,
	output logic                                sample_valid
);

	logic               sensor_present_q;
	logic [15:0]        weight_q;
	logic signed [15:0] x_q, y_q, z_q;
	logic               upd_q;
	logic               out_valid_q;
	logic signed [15:0] pitch_q, roll_q;
	logic               sval_q;

	atd_pkg::atd_ctl_t  ctl;
	logic               rdy, out_ld, out_busy, accept;
	logic signed [15:0] pitch_sm, roll_sm;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_present_q <= 1'b0;
			weight_q         <= atd_pkg::ATD_WEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				atd_pkg::CFG_SENSOR: sensor_present_q <= cfg_data[0];
				atd_pkg::CFG_WEIGHT: weight_q         <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Input transfer
	assign in_stall = !rdy;
	assign accept   = in_valid & rdy;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= accel_x;
			y_q <= accel_y;
			z_q <= accel_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			upd_q <= 1'b0;
		else if (accept)
			upd_q <= sensor_present_q & read_ok;
	end

	// Sequencer and lanes
	assign out_busy = out_valid_q & out_stall;

	atd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.upd      (upd_q),
		.out_busy (out_busy),
		.ctl      (ctl),
		.rdy      (rdy),
		.out_ld   (out_ld)
	);

	atd_lane u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.num    (x_q),
		.leg_a  (y_q),
		.leg_b  (z_q),
		.weight (weight_q),
		.angle  (pitch_sm)
	);

	atd_lane u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.num    (y_q),
		.leg_a  (x_q),
		.leg_b  (z_q),
		.weight (weight_q),
		.angle  (roll_sm)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pitch_q     <= '0;
			roll_q      <= '0;
			sval_q      <= 1'b0;
		end else begin
			if (out_ld) begin
				out_valid_q <= 1'b1;
				pitch_q     <= pitch_sm;
				roll_q      <= roll_sm;
				sval_q      <= upd_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pitch_angle  = pitch_q;
	assign roll_angle   = roll_q;
	assign sample_valid = sval_q;

	// Checks
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input taken on two consecutive cycles");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |=> out_valid)
		else $error("loaded result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !out_ld)
		else $error("waiting result overwritten");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ld |=> ($stable(pitch_angle) && $stable(roll_angle)))
		else $error("result changed without a load");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_angle <= atd_pkg::ATD_ANG_MAX &&
			pitch_angle >= atd_pkg::ATD_ANG_MIN &&
			roll_angle <= atd_pkg::ATD_ANG_MAX &&
			roll_angle >= atd_pkg::ATD_ANG_MIN))
		else $error("angle beyond 90 degrees");

endmodule
